FILE: rtl/epav_pkg.sv
// Types and constants shared by the event packet alignment voter.
`default_nettype none
package epav_pkg;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [30:0] event_sequence;
		logic        last_in_event;
		logic        checksum_good;
		logic [15:0] packet_id;
		logic [15:0] event_counter;
		logic [15:0] beam_clock;
		logic [15:0] fem_event_counter;
		logic [15:0] fem_clock;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        out_packet_id;
		logic [1:0]         status;
		logic signed [31:0] voted_number;
		logic [15:0]        common_clock;
		logic               last;
	} result_t;

	// request types
	localparam logic [1:0] REQ_PACKET   = 2'd0;
	localparam logic [1:0] REQ_SPECIAL  = 2'd1;
	localparam logic [1:0] REQ_NO_PKT   = 2'd2;

	// result status codes
	localparam logic [1:0] ST_ADDED     = 2'd0;
	localparam logic [1:0] ST_CLK_DROP  = 2'd1;
	localparam logic [1:0] ST_BAD_CKSUM = 2'd2;
	localparam logic [1:0] ST_NO_PKT    = 2'd3;

	// front-end id class: id / 1000 == 12
	localparam logic [15:0] FE_ID_LO    = 16'd12000;
	localparam logic [15:0] FE_ID_HI    = 16'd12999;
	localparam logic [15:0] FE_CLK_DLY  = 16'd30;
	localparam logic [15:0] SEQ_LAG     = 16'd2;
	localparam logic [31:0] PREV_RESET  = 32'h8000_0000;

endpackage
`default_nettype wire

FILE: rtl/epav_out_reg.sv
// Output register that holds one result until the downstream side takes it.
`default_nettype none
module epav_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             ld,
	input  wire epav_pkg::result_t d,
	input  wire logic             stall,
	output logic                  free,
	output logic                  valid,
	output epav_pkg::result_t     q
);
	import epav_pkg::*;

	logic valid_q;
	result_t data_q;

	assign free  = !valid_q || !stall;
	assign valid = valid_q;
	assign q     = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= ld;
		end
	end

	always_ff @(posedge clk) begin
		if (ld && free) begin
			data_q <= d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/event_packet_alignment_voter.sv
// Top level of the event packet alignment voter: ingest, vote, correct and emit sequencer.
`default_nettype none
// Packets of one event are taken one at a time and buffered by slot; a request is
// accepted only while the sequencer is idle. A packet with a good checksum is accepted
// and then takes six steps through the one shared 32-bit adder: counter plus rollover,
// rollover shift or front-end substitution, then global, per-slot and special offsets, then the buffer write; a
// bad-checksum packet goes from the first step to the buffer write, and a packet beyond the buffer depth is dropped.
// The last packet of an event starts the vote, which walks the buffer through its single
// read port, with a read state and an evaluate state per visited entry: a scan, the
// pairwise count (an outer walk plus an inner walk per good packet), the offset correction
// when numbers disagree, the clock-ordered emission (one search and one emit walk per
// distinct clock, usually followed by one closing search) and the bad-checksum pass.
// Results leave through an output register, so a stalled result holds the sequencer
// only while it waits to emit. Special requests are counted without leaving idle.
module event_packet_alignment_voter #(
	parameter int MAX_PACKETS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire epav_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output epav_pkg::result_t      out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [31:0]       cfg_data
);
	import epav_pkg::*;

	localparam int IDX_W = $clog2(MAX_PACKETS);
	localparam int CNT_W = $clog2(MAX_PACKETS + 1);
	localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_PACKETS);

	typedef enum logic [4:0] {
		S_IDLE, S_IN_A, S_IN_B, S_IN_C, S_IN_D, S_IN_E, S_IN_W, S_NOPKT,
		S_SC_RD, S_SC_EV, S_VJ_RD, S_VJ_EV, S_VK_RD, S_VK_EV, S_VJ_UPD,
		S_CO_RD, S_CO_EV, S_CO_WR, S_MN_RD, S_MN_EV, S_EQ_RD, S_EQ_EV,
		S_BD_RD, S_BD_EV
	} state_t;

	state_t state_q;

	logic [31:0]      enum_off_q;
	logic [31:0]      special_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] cnt_q;
	in_item_t         in_q;
	logic [31:0]      t_q;
	logic [15:0]      nroll_q;
	logic [31:0]      num_q;
	logic [15:0]      clk_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] kg_q;
	logic             have_good_q;
	logic             multi_num_q;
	logic             multi_clk_q;
	logic [31:0]      fnum_q;
	logic [15:0]      fclk_q;
	logic [31:0]      cnum_q;
	logic [15:0]      cclk_q;
	logic [CNT_W-1:0] cn_q;
	logic [CNT_W-1:0] cc_q;
	logic [CNT_W-1:0] bestn_q;
	logic [CNT_W-1:0] bestc_q;
	logic [31:0]      vj_num_q;
	logic [15:0]      vj_clk_q;
	logic [31:0]      diff_q;
	logic [16:0]      lo_q;
	logic [16:0]      m_q;
	logic [MAX_PACKETS-1:0] rp_vld_q;
	logic [MAX_PACKETS-1:0] off_vld_q;

	// buffers and per-slot state
	logic [31:0] num_mem  [MAX_PACKETS];
	logic [15:0] clk_mem  [MAX_PACKETS];
	logic [15:0] raw_mem  [MAX_PACKETS];
	logic [15:0] id_mem   [MAX_PACKETS];
	logic        good_mem [MAX_PACKETS];
	logic [15:0] roll_mem [MAX_PACKETS];
	logic [31:0] prev_mem [MAX_PACKETS];
	logic [31:0] off_mem  [MAX_PACKETS];

	logic [31:0] rd_num;
	logic [15:0] rd_clk;
	logic [15:0] rd_raw;
	logic [15:0] rd_id;
	logic        rd_good;
	logic [15:0] roll_rd;
	logic [31:0] prev_rd;
	logic [31:0] off_rd;

	logic [IDX_W-1:0] p_idx;
	logic [IDX_W-1:0] ra;
	logic [IDX_W-1:0] ora;
	logic [15:0]      roll_v;
	logic [31:0]      prev_v;
	logic [31:0]      off_v;
	logic [31:0]      alu_a;
	logic [31:0]      alu_b;
	logic             alu_sub;
	logic [31:0]      alu_y;
	logic             roll_lt;
	logic             is_fe;
	logic [15:0]      seq_exp;
	logic             j_end;
	logic             k_end;
	logic             out_free;
	logic             out_ld;
	result_t          res;
	logic             in_acc;

	assign p_idx    = pos_q[IDX_W-1:0];
	assign ra       = (state_q == S_VK_RD) ? k_q : j_q;
	assign ora      = (state_q == S_CO_EV || state_q == S_CO_WR) ? kg_q : p_idx;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign j_end    = (CNT_W'(j_q) == n_q - CNT_W'(1));
	assign k_end    = (CNT_W'(k_q) == n_q - CNT_W'(1));

	assign roll_v  = rp_vld_q[p_idx] ? roll_rd : 16'd0;
	assign prev_v  = rp_vld_q[p_idx] ? prev_rd : PREV_RESET;
	assign off_v   = off_vld_q[ora] ? off_rd : 32'd0;
	assign is_fe   = (in_q.packet_id >= FE_ID_LO) && (in_q.packet_id <= FE_ID_HI);
	assign seq_exp = in_q.event_sequence[15:0] - SEQ_LAG;

	// shared adder
	always_comb begin
		alu_a   = 32'd0;
		alu_b   = 32'd0;
		alu_sub = 1'b0;
		case (state_q)
			S_IN_A: begin
				alu_a = {16'd0, in_q.event_counter};
				alu_b = {16'd0, roll_v};
			end
			S_IN_B: begin
				alu_a = t_q;
				alu_b = {nroll_q, 16'd0};
			end
			S_IN_C: begin
				alu_a = num_q;
				alu_b = enum_off_q;
			end
			S_IN_D: begin
				alu_a = num_q;
				alu_b = off_v;
			end
			S_IN_E: begin
				alu_a = num_q;
				alu_b = special_q;
			end
			S_CO_EV: begin
				alu_a   = rd_num;
				alu_b   = cnum_q;
				alu_sub = 1'b1;
			end
			S_CO_WR: begin
				alu_a   = off_v;
				alu_b   = diff_q;
				alu_sub = 1'b1;
			end
			default: begin
				alu_a = 32'd0;
			end
		endcase
	end

	assign alu_y   = alu_a + (alu_sub ? ~alu_b : alu_b) + {31'd0, alu_sub};
	assign roll_lt = $signed(alu_y) < $signed(prev_v);

	// result payload
	always_comb begin
		res.out_packet_id       = rd_id;
		res.status              = ST_ADDED;
		res.voted_number        = cnum_q;
		res.common_clock        = cclk_q;
		res.last                = (cnt_q == n_q - CNT_W'(1));
		out_ld                  = 1'b0;
		case (state_q)
			S_NOPKT: begin
				res.out_packet_id       = 16'd0;
				res.status              = ST_NO_PKT;
				res.voted_number        = 32'sd0;
				res.common_clock        = 16'd0;
				res.last                = 1'b1;
				out_ld                  = 1'b1;
			end
			S_EQ_EV: begin
				res.status = (multi_clk_q && rd_raw != cclk_q) ? ST_CLK_DROP : ST_ADDED;
				out_ld     = rd_good && (rd_clk == m_q[15:0]);
			end
			S_BD_EV: begin
				res.status = ST_BAD_CKSUM;
				out_ld     = !rd_good;
			end
			default: begin
				out_ld = 1'b0;
			end
		endcase
	end

	epav_out_reg u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.ld    (out_ld),
		.d     (res),
		.stall (out_stall),
		.free  (out_free),
		.valid (out_valid),
		.q     (out_data)
	);

	// packet buffers: single read port
	always_ff @(posedge clk) begin
		if (state_q == S_IN_W) begin
			num_mem[p_idx]  <= num_q;
			clk_mem[p_idx]  <= clk_q;
			raw_mem[p_idx]  <= in_q.beam_clock;
			id_mem[p_idx]   <= in_q.packet_id;
			good_mem[p_idx] <= in_q.checksum_good;
		end
		rd_num  <= num_mem[ra];
		rd_clk  <= clk_mem[ra];
		rd_raw  <= raw_mem[ra];
		rd_id   <= id_mem[ra];
		rd_good <= good_mem[ra];
	end

	// per-slot rollover and previous number
	always_ff @(posedge clk) begin
		if (state_q == S_IN_A && in_q.checksum_good) begin
			roll_mem[p_idx] <= roll_v + {15'd0, roll_lt};
			prev_mem[p_idx] <= alu_y;
		end
		roll_rd <= roll_mem[p_idx];
		prev_rd <= prev_mem[p_idx];
	end

	// per-slot offsets
	always_ff @(posedge clk) begin
		if (state_q == S_CO_WR) begin
			off_mem[kg_q] <= alu_y;
		end
		off_rd <= off_mem[ora];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			enum_off_q  <= 32'd0;
			special_q   <= 32'd0;
			pos_q       <= '0;
			n_q         <= '0;
			cnt_q       <= '0;
			rp_vld_q    <= '0;
			off_vld_q   <= '0;
			j_q         <= '0;
			k_q         <= '0;
			kg_q        <= '0;
			have_good_q <= 1'b0;
			multi_num_q <= 1'b0;
			multi_clk_q <= 1'b0;
			cnum_q      <= 32'd0;
			cclk_q      <= 16'd0;
			bestn_q     <= '0;
			bestc_q     <= '0;
			cn_q        <= '0;
			cc_q        <= '0;
			lo_q        <= '0;
			m_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				enum_off_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						in_q <= in_data;
						case (in_data.req_type)
							REQ_SPECIAL: special_q <= special_q + 32'd1;
							REQ_NO_PKT: begin
								pos_q   <= '0;
								state_q <= S_NOPKT;
							end
							REQ_PACKET: begin
								if (pos_q < MAX_N) begin
									state_q <= S_IN_A;
								end else if (in_data.last_in_event) begin
									// overflow packet still closes the event
									n_q         <= pos_q;
									pos_q       <= '0;
									j_q         <= '0;
									cnt_q       <= '0;
									have_good_q <= 1'b0;
									multi_num_q <= 1'b0;
									multi_clk_q <= 1'b0;
									cnum_q      <= 32'd0;
									cclk_q      <= 16'd0;
									bestn_q     <= '0;
									bestc_q     <= '0;
									state_q     <= S_SC_RD;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_NOPKT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_IN_A: begin
					t_q     <= alu_y;
					nroll_q <= roll_v + {15'd0, roll_lt};
					if (in_q.checksum_good) begin
						rp_vld_q[p_idx] <= 1'b1;
						state_q         <= S_IN_B;
					end else begin
						num_q   <= 32'd0;
						clk_q   <= in_q.beam_clock;
						state_q <= S_IN_W;
					end
				end
				S_IN_B: begin
					if (is_fe && alu_y != {16'd0, seq_exp}) begin
						num_q <= {16'd0, in_q.fem_event_counter - 16'd1};
						clk_q <= in_q.fem_clock + FE_CLK_DLY;
					end else begin
						num_q <= alu_y;
						clk_q <= in_q.beam_clock;
					end
					state_q <= S_IN_C;
				end
				S_IN_C: begin
					num_q   <= alu_y;
					state_q <= S_IN_D;
				end
				S_IN_D: begin
					num_q   <= alu_y;
					state_q <= S_IN_E;
				end
				S_IN_E: begin
					num_q   <= alu_y;
					state_q <= S_IN_W;
				end
				S_IN_W: begin
					if (in_q.last_in_event) begin
						n_q         <= pos_q + CNT_W'(1);
						pos_q       <= '0;
						j_q         <= '0;
						cnt_q       <= '0;
						have_good_q <= 1'b0;
						multi_num_q <= 1'b0;
						multi_clk_q <= 1'b0;
						cnum_q      <= 32'd0;
						cclk_q      <= 16'd0;
						bestn_q     <= '0;
						bestc_q     <= '0;
						state_q     <= S_SC_RD;
					end else begin
						pos_q   <= pos_q + CNT_W'(1);
						state_q <= S_IDLE;
					end
				end
				S_SC_RD: state_q <= S_SC_EV;
				S_SC_EV: begin
					if (rd_good) begin
						if (!have_good_q) begin
							fnum_q <= rd_num;
							fclk_q <= rd_clk;
						end else begin
							if (rd_num != fnum_q) multi_num_q <= 1'b1;
							if (rd_clk != fclk_q) multi_clk_q <= 1'b1;
						end
						have_good_q <= 1'b1;
					end
					if (j_end) begin
						j_q <= '0;
						if (have_good_q || rd_good) begin
							state_q <= S_VJ_RD;
						end else begin
							state_q <= S_BD_RD;
						end
					end else begin
						j_q     <= j_q + IDX_W'(1);
						state_q <= S_SC_RD;
					end
				end
				S_VJ_RD: state_q <= S_VJ_EV;
				S_VJ_EV: begin
					if (rd_good) begin
						vj_num_q <= rd_num;
						vj_clk_q <= rd_clk;
						cn_q     <= '0;
						cc_q     <= '0;
						k_q      <= '0;
						state_q  <= S_VK_RD;
					end else if (j_end) begin
						j_q     <= '0;
						kg_q    <= '0;
						lo_q    <= '0;
						m_q     <= 17'h10000;
						state_q <= multi_num_q ? S_CO_RD : S_MN_RD;
					end else begin
						j_q     <= j_q + IDX_W'(1);
						state_q <= S_VJ_RD;
					end
				end
				S_VK_RD: state_q <= S_VK_EV;
				S_VK_EV: begin
					if (rd_good) begin
						cn_q <= cn_q + CNT_W'(rd_num == vj_num_q);
						cc_q <= cc_q + CNT_W'(rd_clk == vj_clk_q);
					end
					if (k_end) begin
						state_q <= S_VJ_UPD;
					end else begin
						k_q     <= k_q + IDX_W'(1);
						state_q <= S_VK_RD;
					end
				end
				S_VJ_UPD: begin
					if (cn_q > bestn_q ||
					    (cn_q == bestn_q && $signed(vj_num_q) < $signed(cnum_q))) begin
						bestn_q <= cn_q;
						cnum_q  <= vj_num_q;
					end
					if (cc_q > bestc_q || (cc_q == bestc_q && vj_clk_q < cclk_q)) begin
						bestc_q <= cc_q;
						cclk_q  <= vj_clk_q;
					end
					if (j_end) begin
						j_q     <= '0;
						kg_q    <= '0;
						lo_q    <= '0;
						m_q     <= 17'h10000;
						state_q <= multi_num_q ? S_CO_RD : S_MN_RD;
					end else begin
						j_q     <= j_q + IDX_W'(1);
						state_q <= S_VJ_RD;
					end
				end
				S_CO_RD: state_q <= S_CO_EV;
				S_CO_EV: begin
					diff_q <= alu_y;
					if (rd_good && rd_num != cnum_q) begin
						state_q <= S_CO_WR;
					end else begin
						if (rd_good) kg_q <= kg_q + IDX_W'(1);
						if (j_end) begin
							j_q     <= '0;
							state_q <= S_MN_RD;
						end else begin
							j_q     <= j_q + IDX_W'(1);
							state_q <= S_CO_RD;
						end
					end
				end
				S_CO_WR: begin
					off_vld_q[kg_q] <= 1'b1;
					kg_q            <= kg_q + IDX_W'(1);
					if (j_end) begin
						j_q     <= '0;
						state_q <= S_MN_RD;
					end else begin
						j_q     <= j_q + IDX_W'(1);
						state_q <= S_CO_RD;
					end
				end
				S_MN_RD: state_q <= S_MN_EV;
				S_MN_EV: begin
					if (rd_good && {1'b0, rd_clk} >= lo_q && {1'b0, rd_clk} < m_q) begin
						m_q <= {1'b0, rd_clk};
					end
					if (j_end) begin
						j_q <= '0;
						if (m_q[16] && !(rd_good && {1'b0, rd_clk} >= lo_q)) begin
							state_q <= S_BD_RD;
						end else begin
							state_q <= S_EQ_RD;
						end
					end else begin
						j_q     <= j_q + IDX_W'(1);
						state_q <= S_MN_RD;
					end
				end
				S_EQ_RD: state_q <= S_EQ_EV;
				S_EQ_EV: begin
					// hold while the result cannot be taken
					if (!out_ld || out_free) begin
						if (out_ld) cnt_q <= cnt_q + CNT_W'(1);
						if (j_end) begin
							j_q  <= '0;
							lo_q <= m_q + 17'd1;
							m_q  <= 17'h10000;
							state_q <= (m_q == 17'h0ffff) ? S_BD_RD : S_MN_RD;
						end else begin
							j_q     <= j_q + IDX_W'(1);
							state_q <= S_EQ_RD;
						end
					end
				end
				S_BD_RD: state_q <= S_BD_EV;
				S_BD_EV: begin
					if (!out_ld || out_free) begin
						if (out_ld) cnt_q <= cnt_q + CNT_W'(1);
						if (j_end) begin
							state_q <= S_IDLE;
						end else begin
							j_q     <= j_q + IDX_W'(1);
							state_q <= S_BD_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= MAX_N)
		else $error("packet position beyond buffer depth");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ld && out_free && state_q != S_NOPKT) |-> (cnt_q < n_q))
		else $error("more results than buffered packets");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

FILE: dv/event_packet_alignment_voter_tb.sv
// Testbench for the event packet alignment voter: scoreboard, drivers and stimulus.
`default_nettype none

module event_packet_alignment_voter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import epav_pkg::*;

	localparam int SLOTS = 64;
	localparam int CYCLE_LIMIT = 2000000;

	class align_scoreboard;
		logic [31:0] number_offset;
		logic [15:0] rollover[SLOTS];
		logic [31:0] prev_number[SLOTS];
		logic [31:0] slot_ofs[SLOTS];
		logic [31:0] special_count;
		logic [31:0] num_buf[SLOTS];
		logic [15:0] clk_buf[SLOTS];
		logic [15:0] raw_buf[SLOTS];
		logic [15:0] id_buf[SLOTS];
		bit          good_buf[SLOTS];
		int          fill;
		result_t     expected_fates[$];
		int          errors;
		int          matched;

		function new();
			number_offset = '0;
			special_count = '0;
			fill = 0;
			errors = 0;
			matched = 0;
			for (int i = 0; i < SLOTS; i++) begin
				rollover[i] = '0;
				prev_number[i] = PREV_RESET;
				slot_ofs[i] = '0;
			end
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function void push_fate(logic [15:0] id, logic [1:0] st, logic [31:0] num,
				logic [15:0] cclk, bit lst);
			result_t r;
			r.out_packet_id = id;
			r.status = st;
			r.voted_number = num;
			r.common_clock = cclk;
			r.last = lst;
			expected_fates.insert(expected_fates.size(), r);
		endfunction

		function void close_event();
			int n, ngood, first, bestn, bestc, cn, cc, k, lo, m, start;
			logic [31:0] cnum;
			logic [15:0] cclk;
			bit multi_num, multi_clk;
			result_t r;
			n = fill;
			fill = 0;
			ngood = 0;
			first = 0;
			multi_num = 0;
			multi_clk = 0;
			cnum = '0;
			cclk = '0;
			start = expected_fates.size();
			for (int j = 0; j < n; j++) begin
				if (!good_buf[j]) continue;
				if (ngood == 0) first = j;
				else begin
					if (num_buf[j] != num_buf[first]) multi_num = 1;
					if (clk_buf[j] != clk_buf[first]) multi_clk = 1;
				end
				ngood++;
			end
			if (ngood > 0) begin
				bestn = 0;
				bestc = 0;
				cnum = num_buf[first];
				cclk = clk_buf[first];
				for (int j = 0; j < n; j++) begin
					if (!good_buf[j]) continue;
					cn = 0;
					cc = 0;
					for (int i = 0; i < n; i++) begin
						if (!good_buf[i]) continue;
						if (num_buf[i] == num_buf[j]) cn++;
						if (clk_buf[i] == clk_buf[j]) cc++;
					end
					if (cn > bestn || (cn == bestn && $signed(num_buf[j]) < $signed(cnum))) begin
						bestn = cn;
						cnum = num_buf[j];
					end
					if (cc > bestc || (cc == bestc && clk_buf[j] < cclk)) begin
						bestc = cc;
						cclk = clk_buf[j];
					end
				end
				// pull each good slot's offset toward the vote
				if (multi_num) begin
					k = 0;
					for (int j = 0; j < n; j++) begin
						if (!good_buf[j]) continue;
						if (num_buf[j] != cnum) slot_ofs[k] -= num_buf[j] - cnum;
						k++;
					end
				end
				// emit by ascending derived clock, in arrival order where derived clocks are equal
				lo = 0;
				while (lo <= 65535) begin
					m = 65536;
					for (int j = 0; j < n; j++)
						if (good_buf[j] && int'(clk_buf[j]) >= lo && int'(clk_buf[j]) < m)
							m = clk_buf[j];
					if (m > 65535) break;
					for (int j = 0; j < n; j++)
						if (good_buf[j] && int'(clk_buf[j]) == m)
							push_fate(id_buf[j], (multi_clk && raw_buf[j] != cclk) ?
								ST_CLK_DROP : ST_ADDED, cnum, cclk, 0);
					lo = m + 1;
				end
			end
			for (int j = 0; j < n; j++)
				if (!good_buf[j]) push_fate(id_buf[j], ST_BAD_CKSUM, cnum, cclk, 0);
			if (expected_fates.size() > start) begin
				r = expected_fates.pop_back();
				r.last = 1'b1;
				expected_fates.insert(expected_fates.size(), r);
			end
		endfunction

		function void note_request(in_item_t it);
			int p;
			logic [31:0] num;
			logic [15:0] dclk;
			if (it.req_type == REQ_SPECIAL) begin
				special_count++;
				return;
			end
			if (it.req_type == REQ_NO_PKT) begin
				fill = 0;
				push_fate('0, ST_NO_PKT, '0, '0, 1);
				return;
			end
			if (it.req_type != REQ_PACKET) return;
			if (fill < SLOTS) begin
				p = fill;
				num = '0;
				dclk = it.beam_clock;
				if (it.checksum_good) begin
					num = {16'd0, it.event_counter} + {16'd0, rollover[p]};
					if ($signed(num) < $signed(prev_number[p])) rollover[p]++;
					prev_number[p] = num;
					num += {rollover[p], 16'd0};
					if (it.packet_id >= FE_ID_LO && it.packet_id <= FE_ID_HI &&
							num != (({1'b0, it.event_sequence} - 32'd2) & 32'h0000_ffff)) begin
						num = {16'd0, it.fem_event_counter - 16'd1};
						dclk = it.fem_clock + FE_CLK_DLY;
					end
					num += number_offset + slot_ofs[p] + special_count;
				end
				num_buf[p] = num;
				clk_buf[p] = dclk;
				raw_buf[p] = it.beam_clock;
				id_buf[p] = it.packet_id;
				good_buf[p] = it.checksum_good;
				fill = p + 1;
			end
			if (it.last_in_event) close_event();
		endfunction

		task check_result(result_t got);
			result_t e;
			if (expected_fates.size() == 0) begin
				report($sformatf("unexpected result id %0d status %0d",
					got.out_packet_id, got.status));
				return;
			end
			e = expected_fates.pop_front();
			if (got.out_packet_id !== e.out_packet_id)
				report($sformatf("out_packet_id %0d, want %0d", got.out_packet_id,
					e.out_packet_id));
			if (got.status !== e.status)
				report($sformatf("status %0d, want %0d (id %0d)", got.status, e.status,
					e.out_packet_id));
			if (got.voted_number !== e.voted_number)
				report($sformatf("voted_number %0d, want %0d (id %0d)",
					got.voted_number, e.voted_number, e.out_packet_id));
			if (got.common_clock !== e.common_clock)
				report($sformatf("common_clock %0d, want %0d (id %0d)", got.common_clock,
					e.common_clock, e.out_packet_id));
			if (got.last !== e.last)
				report($sformatf("last %0d, want %0d (id %0d)", got.last, e.last,
					e.out_packet_id));
			matched++;
		endtask
	endclass

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	in_item_t in_data;
	logic     out_valid;
	logic     out_stall;
	result_t  out_data;
	logic     cfg_valid;
	logic     cfg_ready;
	logic [31:0] cfg_data;

	align_scoreboard sb;
	int cyc;
	int hold_left;
	int burst_left;
	int sent;
	int events_closed;
	logic [15:0] cur_ctr;
	logic [15:0] cur_clk;
	logic [30:0] cur_seq;

	event_packet_alignment_voter #(.MAX_PACKETS(SLOTS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", cyc,
				sb.expected_fates.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	// receiver: long hold-off on request, otherwise a rotating stall pattern
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				case ((cyc / 300) % 3)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 9) < 3);
					default: out_stall <= ((cyc % 23) < 9);
				endcase
			end
		end
	end

	function automatic in_item_t mk_pkt(logic [30:0] seq, bit lst, bit good,
			logic [15:0] id, logic [15:0] ctr, logic [15:0] bclk, logic [15:0] fctr,
			logic [15:0] fclk);
		in_item_t it;
		it.req_type = REQ_PACKET;
		it.event_sequence = seq;
		it.last_in_event = lst;
		it.checksum_good = good;
		it.packet_id = id;
		it.event_counter = ctr;
		it.beam_clock = bclk;
		it.fem_event_counter = fctr;
		it.fem_clock = fclk;
		return it;
	endfunction

	function automatic in_item_t mk_req(logic [1:0] rt);
		in_item_t it;
		it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom}));
		it.req_type = rt;
		return it;
	endfunction

	task automatic send_request(in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(1, 8);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sb.note_request(it);
		sent++;
		if (it.req_type == REQ_NO_PKT || (it.req_type == REQ_PACKET && it.last_in_event))
			events_closed++;
	endtask

	// hold the input until every expected result is out and the block is idle again
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_fates.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (in_stall) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_offset(logic [31:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.number_offset = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_event(int n);
		logic [15:0] id;
		logic [30:0] seq;
		cur_ctr++;
		cur_clk += 16'($urandom_range(1, 40));
		cur_seq++;
		for (int i = 0; i < n; i++) begin
			// break an event now and then with an empty-event request
			if ($urandom_range(0, 99) < 2) send_request(mk_req(REQ_NO_PKT));
			id = ($urandom_range(0, 3) == 0) ? 16'(FE_ID_LO + $urandom_range(0, 999)) :
				16'($urandom);
			seq = ($urandom_range(0, 2) == 0) ? 31'(cur_ctr + SEQ_LAG) : cur_seq;
			send_request(mk_pkt(seq, i == n - 1, $urandom_range(0, 99) < 85, id,
				($urandom_range(0, 9) == 0) ? 16'($urandom) : cur_ctr,
				($urandom_range(0, 6) == 0) ? 16'($urandom) : cur_clk,
				16'($urandom), 16'($urandom)));
		end
	endtask

	initial begin
		logic [31:0] offsets[5];
		int n, roll;
		sb = new();
		cyc = 0;
		hold_left = 0;
		burst_left = 0;
		sent = 0;
		events_closed = 0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// front-end id whose counter agrees with the sequence, plus id extremes
		send_request(mk_pkt(31'd0, 0, 1, 16'd0, 16'd100, 16'd500, 16'd0, 16'd0));
		send_request(mk_pkt(31'd102, 0, 1, 16'd12345, 16'd100, 16'd500, 16'hffff,
			16'hffff));
		send_request(mk_pkt(31'h7fff_ffff, 1, 1, 16'hffff, 16'd100, 16'd500, 16'd1,
			16'd1));
		// front-end substitution with wrap, disagreement, clock drop, bad checksum
		send_request(mk_pkt(31'd5, 0, 1, FE_ID_LO, 16'd101, 16'd0, 16'd0, 16'hffff));
		send_request(mk_pkt(31'd6, 0, 1, 16'd7, 16'd101, 16'd600, 16'd3, 16'd4));
		send_request(mk_pkt(31'd6, 0, 0, 16'd8, 16'd101, 16'd600, 16'd3, 16'd4));
		send_request(mk_pkt(31'd6, 1, 1, FE_ID_HI, 16'd102, 16'hffff, 16'd9, 16'd9));
		send_request(mk_req(REQ_SPECIAL));
		send_request(mk_req(2'd3));
		send_request(mk_pkt(31'd7, 0, 0, 16'd21, 16'hffff, 16'd10, 16'd0, 16'd0));
		send_request(mk_pkt(31'd7, 1, 0, 16'd22, 16'd0, 16'd11, 16'd0, 16'd0));
		send_request(mk_req(REQ_NO_PKT));
		// slot 0 counter wraps: rollover
		send_request(mk_pkt(31'd8, 1, 1, 16'd30, 16'hffff, 16'd700, 16'd0, 16'd0));
		send_request(mk_pkt(31'd9, 1, 1, 16'd31, 16'd0, 16'd701, 16'd0, 16'd0));
		// packets beyond the slot count are ignored; the last one still closes
		for (int i = 0; i < SLOTS + 2; i++)
			send_request(mk_pkt(31'd10, i == SLOTS + 1, i % 9 != 4, 16'(1000 + i),
				16'd110 + 16'(i % 3 == 0), 16'(800 + (i % 4)), 16'd0, 16'd0));
		drain();

		offsets[0] = 32'h7fff_ffff;
		offsets[1] = 32'h8000_0000;
		offsets[2] = $urandom;
		offsets[3] = 32'hffff_ffff;
		offsets[4] = 32'h0000_0000;
		cur_ctr = 16'hffe0;
		cur_clk = 16'd0;
		cur_seq = 31'h7fff_fff0;
		for (int ph = 0; ph < 5; ph++) begin
			write_offset(offsets[ph]);
			roll = sent + 50;
			while (sent < roll) begin
				case ($urandom_range(0, 19))
					0: send_request(mk_req(REQ_SPECIAL));
					1: send_request(mk_req(REQ_NO_PKT));
					2: send_request(mk_req(2'd3));
					default: begin
						n = ($urandom_range(0, 29) == 0) ? $urandom_range(20, SLOTS) :
							$urandom_range(1, 8);
						random_event(n);
					end
				endcase
			end
			if (ph == 2) begin
				// receiver holds off while the sender keeps offering
				hold_left = 600;
				random_event(6);
				random_event(5);
			end
			drain();
		end

		$display("covered %0d requests in %0d closed events over 6 offset settings",
			sent, events_closed);
		$display("%0d results checked, %0d mismatches", sb.matched, sb.errors);
		if (sb.errors == 0 && sb.expected_fates.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

`default_nettype wire
